// File: design/ers_pkg.sv
// Shared types, codes and helpers for the extent run stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package ers_pkg;

  // Default cap on the size of one encoded value, in bytes.
  localparam longint unsigned MaxValueBytesDef = 64'd16777216;

  // Configuration register indexes (byte address 4 * index).
  localparam logic RegPackKind    = 1'b0;
  localparam logic RegHighestKind = 1'b1;

  localparam logic [7:0] PackKindReset    = 8'd1;
  localparam logic [7:0] HighestKindReset = 8'd2;

  // Result status codes.
  localparam logic [2:0] ErrNone       = 3'd0;
  localparam logic [2:0] ErrTruncated  = 3'd1;
  localparam logic [2:0] ErrBeyond     = 3'd2;
  localparam logic [2:0] ErrKind       = 3'd3;
  localparam logic [2:0] ErrEmptyRun   = 3'd4;
  localparam logic [2:0] ErrPackCount  = 3'd5;
  localparam logic [2:0] ErrTrailing   = 3'd6;

  // Field being assembled.
  typedef enum logic [8:0] {
    PhRuns  = 9'b000000001,
    PhKind  = 9'b000000010,
    PhFirst = 9'b000000100,
    PhCount = 9'b000001000,
    PhChunk = 9'b000010000,
    PhLast  = 9'b000100000,
    PhPoff  = 9'b001000000,
    PhCrc   = 9'b010000000,
    PhTrail = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic        extent_valid;
    logic [7:0]  extent_kind;
    logic [63:0] file_id;
    logic [63:0] extent_offset;
    logic [63:0] extent_length;
    logic [31:0] extent_crc;
    logic        value_end;
    logic [2:0]  error_code;
  } result_t;

  // Bytes in the field of a phase.
  function automatic logic [3:0] phase_len(input phase_t ph);
    logic [3:0] len;
    unique case (ph)
      PhRuns:  len = 4'd4;
      PhKind:  len = 4'd1;
      PhCount: len = 4'd4;
      PhCrc:   len = 4'd4;
      default: len = 4'd8;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: design/ers_in_if.sv
// Byte input channel of the extent run stream decoder.
`timescale 1ns / 1ps
`default_nettype none

interface ers_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [23:0] bytes_after;

  modport source (output valid, output data_byte, output bytes_after, input ready);
  modport sink   (input valid, input data_byte, input bytes_after, output ready);
endinterface

`default_nettype wire

// File: design/ers_out_if.sv
// Extent result channel of the extent run stream decoder.
`timescale 1ns / 1ps
`default_nettype none

interface ers_out_if;
  logic        valid;
  logic        ready;
  logic        extent_valid;
  logic [7:0]  extent_kind;
  logic [63:0] file_id;
  logic [63:0] extent_offset;
  logic [63:0] extent_length;
  logic [31:0] extent_crc;
  logic        value_end;
  logic [2:0]  error_code;

  modport source (output valid, output extent_valid, output extent_kind, output file_id,
                  output extent_offset, output extent_length, output extent_crc,
                  output value_end, output error_code, input ready);
  modport sink   (input valid, input extent_valid, input extent_kind, input file_id,
                  input extent_offset, input extent_length, input extent_crc,
                  input value_end, input error_code, output ready);
endinterface

`default_nettype wire

// File: design/ers_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module ers_out_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output      logic            push_ready,
  input  wire ers_pkg::result_t push_data,
  output      logic            pop_valid,
  input  wire logic            pop_ready,
  output      ers_pkg::result_t pop_data
);

  logic             main_valid;
  logic             skid_valid;
  ers_pkg::result_t main_data;
  ers_pkg::result_t skid_data;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = !skid_valid;
  assign push_fire  = push_valid && !skid_valid;
  assign pop_fire   = main_valid && pop_ready;
  assign pop_valid  = main_valid;
  assign pop_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop_fire) begin
      // Refill the output register, from the skid stage first.
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push_fire;
      end
    end else if (push_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop_fire) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push_fire) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: design/extent_run_stream_decoder.sv
// Top level of the extent run stream decoder: byte parser, registers, result buffer.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role  Payload                                   Transfer
// bytes     sink  data_byte[8], bytes_after[24]              valid && ready
// extents   src   extent_valid, kind, file_id, offset,       valid && ready
//                 length, crc, value_end, error_code[3]
// APB       cfg   paddr[3], pwdata/prdata[32]                psel && penable && pwrite
//
// One byte is taken every cycle; its field update, checks and result are computed in
// the same cycle and land in the two-entry result buffer, whose skid stage keeps the
// byte side moving while a result waits. bytes.ready drops only while both buffer
// entries are full. Reset is synchronous and returns the parser to the run count
// with both registers at their defaults. A byte yields at most one result.

module extent_run_stream_decoder #(
  parameter longint unsigned MAX_VALUE_BYTES = ers_pkg::MaxValueBytesDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ers_in_if.sink           bytes,
  ers_out_if.source        extents,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  // Largest follower count that counts; larger ones are clamped to it.
  localparam logic [32:0] RemCap = 33'(MAX_VALUE_BYTES - 64'd1);

  // ---------------------------------------------------------------- registers
  logic [7:0] pack_kind_code;
  logic [7:0] highest_kind_code;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_kind_code    <= ers_pkg::PackKindReset;
      highest_kind_code <= ers_pkg::HighestKindReset;
    end else if (cfg_write) begin
      // Decode on the word address; byte lanes below it are ignored.
      if (paddr[2] == ers_pkg::RegPackKind) begin
        pack_kind_code <= pwdata[7:0];
      end else begin
        highest_kind_code <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ers_pkg::RegPackKind) begin
      prdata = {24'd0, pack_kind_code};
    end else begin
      prdata = {24'd0, highest_kind_code};
    end
  end

  // ---------------------------------------------------------------- parser state
  ers_pkg::phase_t phase, phase_next;
  logic [2:0]  byte_in_field, byte_in_field_next;
  logic [63:0] field_shift, field_shift_next;
  logic [31:0] runs_left, runs_left_next;
  logic [7:0]  run_kind, run_kind_next;
  logic [63:0] run_first_id, run_first_id_next;
  logic [31:0] run_count, run_count_next;
  logic [31:0] member_index, member_index_next;
  logic [63:0] full_length, full_length_next;
  logic [63:0] final_length, final_length_next;
  logic [63:0] pack_position, pack_position_next;
  logic        discarding, discarding_next;

  // ---------------------------------------------------------------- datapath
  logic             in_fire;
  logic             buf_ready;
  logic             res_valid;
  ers_pkg::result_t res;
  logic [23:0]      rem;
  logic             rem_zero;
  logic [2:0]       bif_inc;
  logic             field_done;
  logic [63:0]      merged;
  logic [31:0]      v32;
  logic [37:0]      runs_bytes;
  logic [33:0]      crc_bytes;
  logic [32:0]      mi_inc;
  logic             member_last;
  logic             is_pack;

  assign bytes.ready = buf_ready;
  assign in_fire     = bytes.valid && buf_ready;

  assign rem = ({9'd0, bytes.bytes_after} > RemCap) ? RemCap[23:0] : bytes.bytes_after;
  assign rem_zero = (rem == 24'd0);

  assign bif_inc    = byte_in_field + 3'd1;
  assign field_done = (bif_inc == 3'd0) || ({1'b0, bif_inc} >= ers_pkg::phase_len(phase));

  // Drop the new byte into its lane of the field being assembled.
  always_comb begin
    merged = field_shift;
    for (int k = 0; k < 8; k++) begin
      if (byte_in_field == 3'(k)) begin
        merged[8*k +: 8] = field_shift[8*k +: 8] | bytes.data_byte;
      end
    end
  end

  assign v32        = merged[31:0];
  assign runs_bytes = {6'd0, v32} + {1'b0, v32, 5'd0};
  assign crc_bytes  = {v32, 2'b00};
  assign mi_inc     = {1'b0, member_index} + 33'd1;
  assign member_last = !(mi_inc < {1'b0, run_count});
  assign is_pack    = (run_kind == pack_kind_code);

  always_comb begin
    logic close;
    logic [2:0] close_code;
    close      = 1'b0;
    close_code = ers_pkg::ErrNone;

    phase_next         = phase;
    byte_in_field_next = byte_in_field;
    field_shift_next   = field_shift;
    runs_left_next     = runs_left;
    run_kind_next      = run_kind;
    run_first_id_next  = run_first_id;
    run_count_next     = run_count;
    member_index_next  = member_index;
    full_length_next   = full_length;
    final_length_next  = final_length;
    pack_position_next = pack_position;
    discarding_next    = discarding;
    res_valid          = 1'b0;
    res                = '0;

    if (in_fire) begin
      if (discarding) begin
        // Skip the rest of a failed value, then start over.
        if (rem_zero) begin
          discarding_next = 1'b0;
        end
      end else if (phase == ers_pkg::PhTrail) begin
        close      = 1'b1;
        close_code = ers_pkg::ErrTrailing;
      end else if (!field_done) begin
        field_shift_next   = merged;
        byte_in_field_next = bif_inc;
        if (rem_zero) begin
          close      = 1'b1;
          close_code = ers_pkg::ErrTruncated;
        end
      end else begin
        field_shift_next   = '0;
        byte_in_field_next = 3'd0;
        unique case (phase)
          ers_pkg::PhRuns: begin
            runs_left_next = v32;
            if (runs_bytes > {14'd0, rem}) begin
              close      = 1'b1;
              close_code = ers_pkg::ErrBeyond;
            end else if (v32 == 32'd0) begin
              phase_next = ers_pkg::PhTrail;
              if (rem_zero) begin
                close      = 1'b1;
                close_code = ers_pkg::ErrNone;
              end
            end else begin
              phase_next = ers_pkg::PhKind;
            end
          end
          ers_pkg::PhKind: begin
            if (merged[7:0] > highest_kind_code) begin
              close      = 1'b1;
              close_code = ers_pkg::ErrKind;
            end else begin
              run_kind_next = merged[7:0];
              phase_next    = ers_pkg::PhFirst;
            end
          end
          ers_pkg::PhFirst: begin
            run_first_id_next = merged;
            phase_next        = ers_pkg::PhCount;
          end
          ers_pkg::PhCount: begin
            if (v32 == 32'd0) begin
              close      = 1'b1;
              close_code = ers_pkg::ErrEmptyRun;
            end else if (is_pack && v32 != 32'd1) begin
              close      = 1'b1;
              close_code = ers_pkg::ErrPackCount;
            end else if (crc_bytes > {10'd0, rem}) begin
              close      = 1'b1;
              close_code = ers_pkg::ErrBeyond;
            end else begin
              run_count_next    = v32;
              member_index_next = 32'd0;
              phase_next        = ers_pkg::PhChunk;
            end
          end
          ers_pkg::PhChunk: begin
            full_length_next = merged;
            phase_next       = ers_pkg::PhLast;
          end
          ers_pkg::PhLast: begin
            final_length_next = merged;
            phase_next        = ers_pkg::PhPoff;
          end
          ers_pkg::PhPoff: begin
            pack_position_next = merged;
            phase_next         = ers_pkg::PhCrc;
          end
          ers_pkg::PhCrc: begin
            res_valid          = 1'b1;
            res.extent_valid   = 1'b1;
            res.extent_kind    = run_kind;
            res.file_id        = run_first_id + {32'd0, member_index};
            res.extent_offset  = is_pack ? pack_position : 64'd0;
            res.extent_length  = member_last ? final_length : full_length;
            res.extent_crc     = v32;
            member_index_next  = mi_inc[31:0];
            if (member_last) begin
              runs_left_next = runs_left - 32'd1;
              if (runs_left == 32'd1) begin
                phase_next = ers_pkg::PhTrail;
                if (rem_zero) begin
                  // Clean end of the list on its final byte.
                  res.value_end = 1'b1;
                  phase_next    = ers_pkg::PhRuns;
                  runs_left_next     = '0;
                  run_kind_next      = '0;
                  run_first_id_next  = '0;
                  run_count_next     = '0;
                  member_index_next  = '0;
                  full_length_next   = '0;
                  final_length_next  = '0;
                  pack_position_next = '0;
                end
              end else begin
                phase_next = ers_pkg::PhKind;
              end
            end
            if (rem_zero && phase_next != ers_pkg::PhRuns) begin
              close      = 1'b1;
              close_code = ers_pkg::ErrTruncated;
            end
          end
          default: begin
            phase_next = ers_pkg::PhTrail;
          end
        endcase
        // A header field ending the value cuts the list short, bar a zero run count.
        if (rem_zero && !close && phase != ers_pkg::PhCrc) begin
          close      = 1'b1;
          close_code = ers_pkg::ErrTruncated;
        end
      end

      // Close the value: replace any extent, clear the parse, skip what is left.
      if (close) begin
        res_valid          = 1'b1;
        res                = '0;
        res.value_end      = 1'b1;
        res.error_code     = close_code;
        phase_next         = ers_pkg::PhRuns;
        byte_in_field_next = '0;
        field_shift_next   = '0;
        runs_left_next     = '0;
        run_kind_next      = '0;
        run_first_id_next  = '0;
        run_count_next     = '0;
        member_index_next  = '0;
        full_length_next   = '0;
        final_length_next  = '0;
        pack_position_next = '0;
        discarding_next    = !rem_zero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ers_pkg::PhRuns;
      byte_in_field <= '0;
      field_shift   <= '0;
      runs_left     <= '0;
      run_kind      <= '0;
      run_first_id  <= '0;
      run_count     <= '0;
      member_index  <= '0;
      full_length   <= '0;
      final_length  <= '0;
      pack_position <= '0;
      discarding    <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_in_field <= byte_in_field_next;
      field_shift   <= field_shift_next;
      runs_left     <= runs_left_next;
      run_kind      <= run_kind_next;
      run_first_id  <= run_first_id_next;
      run_count     <= run_count_next;
      member_index  <= member_index_next;
      full_length   <= full_length_next;
      final_length  <= final_length_next;
      pack_position <= pack_position_next;
      discarding    <= discarding_next;
    end
  end

  // ---------------------------------------------------------------- result buffer
  ers_pkg::result_t out_data;

  ers_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push_valid(res_valid),
    .push_ready(buf_ready),
    .push_data (res),
    .pop_valid (extents.valid),
    .pop_ready (extents.ready),
    .pop_data  (out_data)
  );

  assign extents.extent_valid  = out_data.extent_valid;
  assign extents.extent_kind   = out_data.extent_kind;
  assign extents.file_id       = out_data.file_id;
  assign extents.extent_offset = out_data.extent_offset;
  assign extents.extent_length = out_data.extent_length;
  assign extents.extent_crc    = out_data.extent_crc;
  assign extents.value_end     = out_data.value_end;
  assign extents.error_code    = out_data.error_code;

  // ---------------------------------------------------------------- assertions
  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && discarding) |-> !res_valid)
    else $error("result produced while skipping a failed value");

  a_trailing_reported: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !discarding && phase == ers_pkg::PhTrail) |-> (res_valid && res.value_end))
    else $error("byte after a complete list did not close the value");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !bytes.ready |-> extents.valid)
    else $error("byte side stalled with an empty result register");

  a_error_no_extent: assert property (@(posedge clk) disable iff (rst)
    (extents.valid && extents.error_code != ers_pkg::ErrNone) |->
      (!extents.extent_valid && extents.value_end))
    else $error("error result carries an extent or does not close the value");

endmodule

`default_nettype wire
